// ===== src/gsbp_pkg.sv =====
// Shared types and constants of the gshare branch predictor.
// No dependencies; used by gsbp_out_fifo, the top level and the testbench.
`default_nettype none

package gsbp_pkg;

  localparam int HIST_W          = 12;  // global history register width
  localparam int HLEN_W          = 4;   // history length register width
  localparam int HLEN_RESET      = 8;
  localparam int PC_W            = 32;
  localparam int PC_LSB          = 2;   // instructions are word aligned
  localparam int TALLY_W         = 32;
  localparam int TAKEN_THRESHOLD = 4;
  localparam int COUNTER_RESET   = 4;
  localparam int CTR_SAT_MIN     = 0;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 72;

  // One result; the last field sits in the lowest bits.
  typedef struct packed {
    logic [TALLY_W-1:0] total_mispredictions;
    logic [TALLY_W-1:0] total_predictions;
    logic               mispredict;
    logic               predict_taken;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== src/gsbp_table.sv =====
// Counter table: single-port-write, single-port-read synchronous memory with
// a registered read and a clearing pass after reset. Depends on nothing.
`default_nettype none

module gsbp_table #(
  parameter int              ADDR_W    = 12,
  parameter int              DATA_W    = 3,
  parameter logic [DATA_W-1:0] RESET_VAL = '0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   busy
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  // After reset every entry is swept back to its reset value, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !rst) begin
      mem[clr_addr] <= RESET_VAL;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/gsbp_out_fifo.sv =====
// Three-entry result queue between the update stage and the output stream.
// Depends on gsbp_pkg for the result type.
`default_nettype none

module gsbp_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire gsbp_pkg::result_t push_data,
  input  wire logic             pop,
  output gsbp_pkg::result_t     head,
  output logic                  not_empty,
  output logic [1:0]            count
);

  localparam int DEPTH = 3;

  gsbp_pkg::result_t entries [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign head      = entries[rd_ptr];
  assign not_empty = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/gshare_branch_predictor_top.sv =====
// Gshare branch predictor top level: index hashing, counter update stage,
// tallies. Depends on gsbp_pkg, gsbp_table and gsbp_out_fifo.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata       | branch_pc, taken
//  m_axis   | m_axis_tvalid/tready/tdata       | prediction, mispredict, tallies
//  cfg      | cfg_valid/cfg_ready/cfg_data     | history_length
//
// One branch per cycle while m_axis_tready stays high and the table is not being cleared.
// The counter is read when the input transfers; the update stage then updates it, writes
// it back and queues the result, and m_axis_tvalid follows the registered queue count; a
// read that hits the entry being written takes the forwarded value.
// After reset all 2**INDEX_BITS table entries are swept back to the reset value with s_axis_tready low.
// Input stalls once three results are queued or in the update stage.
`default_nettype none

module gshare_branch_predictor_top #(
  parameter int INDEX_BITS  = 12,
  parameter int CTR_SAT_MAX = 7
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // bits: [31:0] branch_pc, [32] taken, rest zero
  input  wire logic [gsbp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // bits: [0] predict_taken, [1] mispredict, [33:2] total_predictions,
  // [65:34] total_mispredictions, rest zero
  output logic [gsbp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  input  wire logic [gsbp_pkg::HLEN_W-1:0]          cfg_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready
);

  localparam int CNT_BITS = $clog2(CTR_SAT_MAX + 1);
  localparam int CTR_W    = (CNT_BITS > 3) ? CNT_BITS : 3;
  localparam int LEN_CAP  = (INDEX_BITS < gsbp_pkg::HIST_W) ? INDEX_BITS : gsbp_pkg::HIST_W;
  localparam int IX_W     = (INDEX_BITS > gsbp_pkg::HIST_W) ? INDEX_BITS : gsbp_pkg::HIST_W;

  // Configuration and history
  logic [gsbp_pkg::HLEN_W-1:0] hist_len;
  logic [gsbp_pkg::HIST_W-1:0] hist;
  logic [gsbp_pkg::HLEN_W-1:0] len_eff;
  logic [gsbp_pkg::HIST_W-1:0] hist_sel;
  logic [IX_W-1:0]             hist_ext;
  logic [INDEX_BITS-1:0]       rd_idx;

  logic [gsbp_pkg::PC_W-1:0] in_pc;
  logic                      in_taken;
  logic                      in_xfer;

  // Update stage
  logic                  s1_valid;
  logic [INDEX_BITS-1:0] s1_idx;
  logic                  s1_taken;
  logic [CTR_W-1:0]      rd_data;
  logic                  fwd_valid;
  logic [INDEX_BITS-1:0] fwd_idx;
  logic [CTR_W-1:0]      fwd_val;
  logic [CTR_W-1:0]      ctr_cur;
  logic [CTR_W:0]        ctr_inc;
  logic [CTR_W-1:0]      ctr_new;
  logic                  pred;
  logic                  miss;

  logic [gsbp_pkg::TALLY_W-1:0] pred_tally;
  logic [gsbp_pkg::TALLY_W-1:0] miss_tally;
  logic [gsbp_pkg::TALLY_W-1:0] pred_tally_next;
  logic [gsbp_pkg::TALLY_W-1:0] miss_tally_next;

  logic              table_busy;
  gsbp_pkg::result_t res;
  gsbp_pkg::result_t head;
  logic              fifo_not_empty;
  logic [1:0]        fifo_count;
  logic              out_xfer;

  assign in_pc    = s_axis_tdata[gsbp_pkg::PC_W-1:0];
  assign in_taken = s_axis_tdata[gsbp_pkg::PC_W];
  assign cfg_ready = 1'b1;

  // Room is counted conservatively: queue plus the item in the update stage.
  assign s_axis_tready = !table_busy && ({1'b0, fifo_count} + {2'b0, s1_valid} < 3'd3);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Index hash: newest len_eff history bits folded onto the low index bits.
  always_comb begin
    len_eff = hist_len;
    if (len_eff > gsbp_pkg::HLEN_W'(LEN_CAP)) begin
      len_eff = gsbp_pkg::HLEN_W'(LEN_CAP);
    end
    if (len_eff == '0) begin
      hist_sel = '0;
    end else begin
      hist_sel = hist >> (gsbp_pkg::HLEN_W'(gsbp_pkg::HIST_W) - len_eff);
    end
    hist_ext = IX_W'(hist_sel);
    rd_idx   = in_pc[INDEX_BITS+gsbp_pkg::PC_LSB-1:gsbp_pkg::PC_LSB]
               ^ hist_ext[INDEX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= gsbp_pkg::HLEN_W'(gsbp_pkg::HLEN_RESET);
      hist     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hist_len <= cfg_data;
      end
      if (in_xfer) begin
        hist <= {in_taken, hist[gsbp_pkg::HIST_W-1:1]};
      end
    end
  end

  gsbp_table #(
    .ADDR_W    (INDEX_BITS),
    .DATA_W    (CTR_W),
    .RESET_VAL (CTR_W'(gsbp_pkg::COUNTER_RESET))
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_xfer),
    .rd_addr (rd_idx),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_idx),
    .wr_data (ctr_new),
    .busy    (table_busy)
  );

  // The memory returns the old value when the previous item wrote the same
  // entry on the edge of this item's read; the forwarded copy covers that.
  always_comb begin
    ctr_cur = (fwd_valid && fwd_idx == s1_idx) ? fwd_val : rd_data;
    pred    = (ctr_cur >= CTR_W'(gsbp_pkg::TAKEN_THRESHOLD));
    miss    = (pred != s1_taken);
    ctr_inc = {1'b0, ctr_cur} + 1'b1;
    if (s1_taken) begin
      ctr_new = (ctr_inc > (CTR_W + 1)'(CTR_SAT_MAX)) ? CTR_W'(CTR_SAT_MAX)
                                                      : ctr_inc[CTR_W-1:0];
    end else begin
      ctr_new = (ctr_cur > CTR_W'(gsbp_pkg::CTR_SAT_MIN)) ? ctr_cur - 1'b1
                                                          : CTR_W'(gsbp_pkg::CTR_SAT_MIN);
    end
    pred_tally_next = (pred_tally != '1) ? pred_tally + 1'b1 : pred_tally;
    miss_tally_next = (miss && miss_tally != '1) ? miss_tally + 1'b1 : miss_tally;
    res.predict_taken        = pred;
    res.mispredict           = miss;
    res.total_predictions    = pred_tally_next;
    res.total_mispredictions = miss_tally_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
      pred_tally <= '0;
      miss_tally <= '0;
    end else begin
      s1_valid  <= in_xfer;
      fwd_valid <= s1_valid;
      if (s1_valid) begin
        pred_tally <= pred_tally_next;
        miss_tally <= miss_tally_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_idx   <= rd_idx;
      s1_taken <= in_taken;
    end
    if (s1_valid) begin
      fwd_idx <= s1_idx;
      fwd_val <= ctr_new;
    end
  end

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  gsbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (res),
    .pop       (out_xfer),
    .head      (head),
    .not_empty (fifo_not_empty),
    .count     (fifo_count)
  );

  assign m_axis_tvalid = fifo_not_empty;
  assign m_axis_tdata  = gsbp_pkg::OUT_TDATA_W'(head);

  // The queue never holds more than its three entries.
  assert property (@(posedge clk) disable iff (rst) fifo_count != 2'd3 || !s1_valid || out_xfer)
    else $error("result queue overflow");

  // Mispredictions can never outnumber predictions.
  assert property (@(posedge clk) disable iff (rst) miss_tally <= pred_tally)
    else $error("misprediction tally above prediction tally");

  // No branch enters while the table is being cleared.
  assert property (@(posedge clk) disable iff (rst) table_busy |-> !s1_valid && !in_xfer)
    else $error("branch accepted during table clearing");

  // Every processed branch leaves a nonzero prediction tally behind.
  assert property (@(posedge clk) disable iff (rst) s1_valid |=> pred_tally != '0)
    else $error("prediction tally not advanced");

endmodule

`default_nettype wire

// ===== verif/tb_gshare_branch_predictor_top.sv =====
// Self-checking testbench for gshare_branch_predictor_top: a directed table, then random
// branch streams under several history lengths, with random idling on both streams.
// Depends on gsbp_pkg and the RTL in src.
`timescale 1ns / 100ps

module tb_gshare_branch_predictor_top;

  localparam int INDEX_BITS   = 12;
  localparam int CTR_SAT_MAX  = 7;
  localparam int TABLE_DEPTH  = 2 ** INDEX_BITS;
  localparam int POOL_SIZE    = 24;
  localparam int PHASE_ITEMS  = 194;
  localparam int NUM_PHASES   = 9;
  localparam int LONG_HOLD    = 48;
  localparam int HOLD_AFTER   = 900;
  localparam int NUM_DIR      = 24;

  typedef enum logic {ROW_BRANCH, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] pc;
    logic        tk;
    logic [3:0]  hlen;
    logic        typed;
    logic        exp_pred;
    logic        exp_miss;
  } dir_row_t;

  logic                             clk;
  logic                             rst;
  logic [gsbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [gsbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [gsbp_pkg::HLEN_W-1:0]      cfg_data;
  logic                             cfg_valid;
  logic                             cfg_ready;

  // Predictor state.
  logic [7:0]                    sat_ctr [TABLE_DEPTH];
  logic [gsbp_pkg::HIST_W-1:0]   ghist;
  logic [gsbp_pkg::TALLY_W-1:0]  pred_tally;
  logic [gsbp_pkg::TALLY_W-1:0]  miss_tally;
  logic [gsbp_pkg::HLEN_W-1:0]   hist_len;

  gsbp_pkg::result_t pending_results[$];
  int      n_errors = 0;
  int      rx_count = 0;
  bit      burst_mode;
  bit      long_hold_done = 1'b0;

  // Rows of branch PC and outcome, with rows that switch history length in between.
  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_BRANCH, 32'h0000_0000, 1'b0, 4'd0,  1'b1, 1'b1, 1'b1},
    '{ROW_BRANCH, 32'h0000_0000, 1'b0, 4'd0,  1'b1, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'hFFFF_FFFF, 1'b1, 4'd0,  1'b1, 1'b1, 1'b0},
    '{ROW_BRANCH, 32'hFFFF_FFFF, 1'b1, 4'd0,  1'b1, 1'b1, 1'b0},
    '{ROW_BRANCH, 32'h0000_0010, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_CFG,    32'h0000_0000, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0040, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0040, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0040, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0040, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0040, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0080, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0080, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0080, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0080, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0080, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0080, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_CFG,    32'h0000_0000, 1'b0, 4'd12, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'hFFFF_FFFC, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0004, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_CFG,    32'h0000_0000, 1'b0, 4'd15, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h1234_5678, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h8765_4320, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, 32'h0000_0010, 1'b1, 4'd0,  1'b0, 1'b0, 1'b0}
  };

  logic [gsbp_pkg::HLEN_W-1:0] phase_len [NUM_PHASES] = '{4'd1, 4'd12, 4'd0, 4'd15, 4'd5,
                                                          4'd13, 4'd10, 4'd3, 4'd14};

  gshare_branch_predictor_top #(
    .INDEX_BITS  (INDEX_BITS),
    .CTR_SAT_MAX (CTR_SAT_MAX)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // Works out the outcome of one branch and advances the predictor state.
  task automatic predict_branch(input logic [31:0] pc, input logic tk,
                                output gsbp_pkg::result_t r);
    int unsigned           len;
    logic [INDEX_BITS-1:0] idx;
    int                    c;
    len = 32'(hist_len);
    if (len > INDEX_BITS) len = INDEX_BITS;
    if (len > gsbp_pkg::HIST_W) len = gsbp_pkg::HIST_W;
    idx = pc[INDEX_BITS+gsbp_pkg::PC_LSB-1:gsbp_pkg::PC_LSB];
    if (len > 0) idx = idx ^ INDEX_BITS'(ghist >> (gsbp_pkg::HIST_W - len));
    c = int'(sat_ctr[idx]);
    r = '0;
    r.predict_taken = (c >= gsbp_pkg::TAKEN_THRESHOLD);
    r.mispredict    = (r.predict_taken != tk);
    if (tk) c = (c + 1 > CTR_SAT_MAX) ? CTR_SAT_MAX : c + 1;
    else    c = (c > gsbp_pkg::CTR_SAT_MIN) ? c - 1 : gsbp_pkg::CTR_SAT_MIN;
    sat_ctr[idx] = 8'(c);
    ghist = {tk, ghist[gsbp_pkg::HIST_W-1:1]};
    if (pred_tally != '1) pred_tally = pred_tally + 1;
    if (r.mispredict && miss_tally != '1) miss_tally = miss_tally + 1;
    r.total_predictions    = pred_tally;
    r.total_mispredictions = miss_tally;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_branch(input logic [31:0] pc, input logic tk, input logic typed,
                             input logic exp_pred, input logic exp_miss);
    int                gap;
    gsbp_pkg::result_t r;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {{(gsbp_pkg::IN_TDATA_W-gsbp_pkg::PC_W-1){1'b0}}, tk, pc};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_branch(pc, tk, r);
    if (typed) begin
      r.predict_taken = exp_pred;
      r.mispredict    = exp_miss;
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  // Writes the history length once every expected result has come back.
  task automatic write_hist_len(input logic [gsbp_pkg::HLEN_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    hist_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    gsbp_pkg::result_t got;
    gsbp_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = gsbp_pkg::result_t'(m_axis_tdata[gsbp_pkg::RESULT_W-1:0]);
      rx_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $realtime, got);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        report("predict_taken", 32'(want.predict_taken), 32'(got.predict_taken));
        report("mispredict", 32'(want.mispredict), 32'(got.mispredict));
        report("total_predictions", want.total_predictions, got.total_predictions);
        report("total_mispredictions", want.total_mispredictions, got.total_mispredictions);
      end
    end
  end

  // Result receiver with random stalls and one long hold-off.
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = burst_mode ? 0 : $urandom_range(0, 4);
      if (!long_hold_done && rx_count >= HOLD_AFTER) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Reset, directed table, random phases, end of run.
  initial begin
    logic [31:0] pool_pc   [POOL_SIZE];
    int          pool_bias [POOL_SIZE];
    logic        pool_alt  [POOL_SIZE];
    logic [31:0] pc;
    logic        tk;
    int          k;

    rst            = 1'b1;
    s_axis_tdata   = '0;
    s_axis_tvalid  = 1'b0;
    cfg_data       = '0;
    cfg_valid      = 1'b0;
    burst_mode     = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) sat_ctr[i] = 8'(gsbp_pkg::COUNTER_RESET);
    ghist      = '0;
    pred_tally = '0;
    miss_tally = '0;
    hist_len   = gsbp_pkg::HLEN_W'(gsbp_pkg::HLEN_RESET);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_hist_len(dir_rows[i].hlen);
      else send_branch(dir_rows[i].pc, dir_rows[i].tk, dir_rows[i].typed,
                       dir_rows[i].exp_pred, dir_rows[i].exp_miss);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_hist_len(phase_len[ph]);
      burst_mode = (ph == 2 || ph == 6);
      // A small set of hot branches, most with steady habits, so counters saturate and the
      // history pattern matters; the rest are arbitrary branches.
      for (int i = 0; i < POOL_SIZE; i++) begin
        pool_pc[i]   = $urandom;
        pool_bias[i] = $urandom_range(0, 3);
        pool_alt[i]  = 1'($urandom_range(0, 1));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 75) begin
          k  = $urandom_range(0, POOL_SIZE - 1);
          pc = pool_pc[k];
          case (pool_bias[k])
            0: tk = ($urandom_range(0, 9) == 0);
            1: tk = ($urandom_range(0, 9) != 0);
            2: begin
              pool_alt[k] = ~pool_alt[k];
              tk          = pool_alt[k];
            end
            default: tk = 1'($urandom_range(0, 1));
          endcase
        end else begin
          pc = $urandom;
          tk = 1'($urandom_range(0, 1));
        end
        send_branch(pc, tk, 1'b0, 1'b0, 1'b0);
      end
    end
    burst_mode = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/gsbp_pkg.sv
src/gsbp_table.sv
src/gsbp_out_fifo.sv
src/gshare_branch_predictor_top.sv
verif/tb_gshare_branch_predictor_top.sv
